### hw/rtl/ftu_pkg.sv
`timescale 1ns / 1ps
// package for the flow table update unit
// holds sizes, status codes, sequencer states, beat types and the entry type; no dependencies
package ftu_pkg;
  localparam int unsigned BucketsDef = 1024;
  localparam int unsigned WaysDef    = 4;
  localparam int unsigned BktW       = 10;
  localparam int unsigned WayW       = 2;
  localparam int unsigned StatW      = 3;

  typedef enum logic [StatW-1:0] {
    ST_UPDATED      = 3'd0,
    ST_RESTARTED    = 3'd1,
    ST_INSERTED     = 3'd2,
    ST_FULL         = 3'd3,
    ST_DRAIN_ACTIVE = 3'd4,
    ST_DRAIN_IDLE   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_CMP,
    S_WRITE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [0:0]     mode;
    logic [31:0]    src_ip;
    logic [31:0]    dst_ip;
    logic [15:0]    src_port;
    logic [15:0]    dst_port;
    logic [15:0]    pkt_len;
    logic [63:0]    stamp;
    logic [BktW-1:0] drain_bucket;
    logic [WayW-1:0] drain_way;
  } in_beat_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [BktW-1:0]  bucket;
    logic [WayW-1:0]  way;
    logic [31:0]      flow_src_ip;
    logic [31:0]      flow_dst_ip;
    logic [15:0]      flow_src_port;
    logic [15:0]      flow_dst_port;
    logic [31:0]      packets;
    logic [63:0]      total_bytes;
    logic [63:0]      first_time;
    logic [63:0]      last_time;
  } out_beat_t;

  // one stored entry, flags kept apart
  typedef struct packed {
    logic [31:0] sip;
    logic [31:0] dip;
    logic [31:0] ports;
    logic [31:0] pk;
    logic [63:0] by;
    logic [63:0] ft;
    logic [63:0] lt;
  } entry_t;
endpackage

### hw/rtl/ftu_if.sv
`timescale 1ns / 1ps
// valid/ready channels for input and result beats
// depends on ftu_pkg
interface ftu_in_if (input logic clk);
  logic valid;
  logic ready;
  ftu_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftu_out_if (input logic clk);
  logic valid;
  logic ready;
  ftu_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/ftu_store.sv
`timescale 1ns / 1ps
// entry memory plus flag memory, one port each, registered read
// depends on ftu_pkg
module ftu_store #(
  parameter int unsigned Entries = 4096,
  parameter int unsigned AddrW   = 12
) (
  input  logic                 clk,
  input  logic [AddrW-1:0]     addr,
  input  logic                 ent_we,
  input  ftu_pkg::entry_t      ent_wdata,
  input  logic                 flg_we,
  input  logic [1:0]           flg_wdata,
  output ftu_pkg::entry_t      ent_rdata,
  output logic [1:0]           flg_rdata
);
  import ftu_pkg::*;
  entry_t     ent_mem [Entries];
  logic [1:0] flg_mem [Entries];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[addr] <= ent_wdata;
    end
    ent_rdata <= ent_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (flg_we) begin
      flg_mem[addr] <= flg_wdata;
    end
    flg_rdata <= flg_mem[addr];
  end
endmodule

### hw/rtl/ftu_seq.sv
`timescale 1ns / 1ps
// sequencer: clears flags after reset, walks the ways of a bucket through one
// shared key compare, then writes back and forms the result; depends on ftu_pkg
module ftu_seq #(
  parameter int unsigned Buckets = ftu_pkg::BucketsDef,
  parameter int unsigned Ways    = ftu_pkg::WaysDef,
  parameter int unsigned AddrW   = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  ftu_in_if.sink           in_ch,
  ftu_out_if.source        out_ch,
  output logic [AddrW-1:0] addr,
  output logic             ent_we,
  output ftu_pkg::entry_t  ent_wdata,
  output logic             flg_we,
  output logic [1:0]       flg_wdata,
  input  ftu_pkg::entry_t  ent_rdata,
  input  logic [1:0]       flg_rdata
);
  import ftu_pkg::*;
  localparam int unsigned WIdxW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned WCntW = $clog2(Ways + 1);
  localparam int unsigned BIdxW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned Entries = Buckets * Ways;

  state_t          state_r, state_nxt;
  in_beat_t        req_r, req_nxt;
  logic [BIdxW-1:0] bkt_r, bkt_nxt;
  logic [WIdxW-1:0] way_r, way_nxt;
  logic [WCntW-1:0] free_r, free_nxt;
  logic [AddrW-1:0] clr_r, clr_nxt;
  out_beat_t        res_r, res_nxt;
  logic             ovld_r, ovld_nxt;

  logic [31:0]      ports_w, hash_w;
  logic             bad_drain;
  logic [AddrW-1:0] base_w;
  logic             key_eq;

  assign ports_w = {req_r.dst_port, req_r.src_port};
  assign hash_w  = req_r.src_ip ^ req_r.dst_ip ^ ports_w;
  assign bad_drain = (32'(req_r.drain_bucket) >= 32'(Buckets)) ||
                     (32'(req_r.drain_way) >= 32'(Ways));
  assign base_w = AddrW'(bkt_r) * AddrW'(Ways);
  assign key_eq = flg_rdata[1] && ent_rdata.sip == req_r.src_ip &&
                  ent_rdata.dip == req_r.dst_ip && ent_rdata.ports == ports_w;

  assign in_ch.ready  = (state_r == S_IDLE) && !ovld_r;
  assign out_ch.valid = ovld_r;
  assign out_ch.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    bkt_r  <= bkt_nxt;
    way_r  <= way_nxt;
    free_r <= free_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    bkt_nxt   = bkt_r;
    way_nxt   = way_r;
    free_nxt  = free_r;
    clr_nxt   = clr_r;
    res_nxt   = res_r;
    ovld_nxt  = ovld_r && !out_ch.ready;
    addr      = base_w + AddrW'(way_r);
    ent_we    = 1'b0;
    flg_we    = 1'b0;
    flg_wdata = 2'b11;
    ent_wdata = ent_rdata;
    unique case (state_r)
      S_CLEAR: begin
        addr      = clr_r;
        flg_we    = 1'b1;
        flg_wdata = 2'b00;
        clr_nxt   = clr_r + 1'b1;
        if (32'(clr_r) == 32'(Entries - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          req_nxt   = in_ch.data;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // set up first address
        way_nxt  = '0;
        free_nxt = WCntW'(Ways);
        if (req_r.mode[0]) begin
          bkt_nxt = BIdxW'(req_r.drain_bucket);
          way_nxt = WIdxW'(req_r.drain_way);
          if (bad_drain) begin
            res_nxt = '0;
            res_nxt.status = ST_DRAIN_IDLE;
            res_nxt.bucket = req_r.drain_bucket;
            res_nxt.way    = req_r.drain_way;
            ovld_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_CMP;
          end
        end else begin
          bkt_nxt   = BIdxW'(hash_w % Buckets);
          state_nxt = S_CMP;
        end
        addr = AddrW'(bkt_nxt) * AddrW'(Ways) + AddrW'(way_nxt);
      end
      S_CMP: begin
        // read data for way_r is valid here
        if (req_r.mode[0]) begin
          res_nxt = '0;
          res_nxt.status = ST_DRAIN_IDLE;
          res_nxt.bucket = req_r.drain_bucket;
          res_nxt.way    = req_r.drain_way;
          if (flg_rdata[1]) begin
            if (flg_rdata[0]) res_nxt.status = ST_DRAIN_ACTIVE;
            res_nxt.flow_src_ip   = ent_rdata.sip;
            res_nxt.flow_dst_ip   = ent_rdata.dip;
            res_nxt.flow_src_port = ent_rdata.ports[15:0];
            res_nxt.flow_dst_port = ent_rdata.ports[31:16];
            res_nxt.packets       = ent_rdata.pk;
            res_nxt.total_bytes   = ent_rdata.by;
            res_nxt.first_time    = ent_rdata.ft;
            res_nxt.last_time     = ent_rdata.lt;
            flg_we    = 1'b1;
            flg_wdata = 2'b10;
          end
          ovld_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else if (key_eq) begin
          free_nxt  = WCntW'(way_r);
          res_nxt.status = flg_rdata[0] ? ST_UPDATED : ST_RESTARTED;
          state_nxt = S_WRITE;
        end else begin
          if (free_r == WCntW'(Ways) && !(flg_rdata[1] && flg_rdata[0])) begin
            free_nxt = WCntW'(way_r);
          end
          if (32'(way_r) == 32'(Ways - 1)) begin
            if (free_nxt == WCntW'(Ways)) begin
              res_nxt = '0;
              res_nxt.status        = ST_FULL;
              res_nxt.bucket        = BktW'(bkt_r);
              res_nxt.flow_src_ip   = req_r.src_ip;
              res_nxt.flow_dst_ip   = req_r.dst_ip;
              res_nxt.flow_src_port = req_r.src_port;
              res_nxt.flow_dst_port = req_r.dst_port;
              ovld_nxt  = 1'b1;
              state_nxt = S_OUT;
            end else begin
              res_nxt.status = ST_INSERTED;
              state_nxt = S_WRITE;
            end
          end else begin
            way_nxt = way_r + 1'b1;
            addr    = base_w + AddrW'(way_nxt);
          end
        end
      end
      S_WRITE: begin
        // way_r holds the hit way; free_r the target way
        addr = base_w + AddrW'(free_r[WIdxW-1:0]);
        ent_we = 1'b1;
        flg_we = 1'b1;
        if (res_r.status == ST_UPDATED) begin
          ent_wdata.pk = ent_rdata.pk + 32'd1;
          ent_wdata.by = ent_rdata.by + 64'(req_r.pkt_len);
          ent_wdata.lt = req_r.stamp;
        end else begin
          ent_wdata.sip   = req_r.src_ip;
          ent_wdata.dip   = req_r.dst_ip;
          ent_wdata.ports = ports_w;
          ent_wdata.pk    = 32'd1;
          ent_wdata.by    = 64'(req_r.pkt_len);
          ent_wdata.ft    = req_r.stamp;
          ent_wdata.lt    = req_r.stamp;
        end
        res_nxt.bucket        = BktW'(bkt_r);
        res_nxt.way           = WayW'(free_r);
        res_nxt.flow_src_ip   = ent_wdata.sip;
        res_nxt.flow_dst_ip   = ent_wdata.dip;
        res_nxt.flow_src_port = ent_wdata.ports[15:0];
        res_nxt.flow_dst_port = ent_wdata.ports[31:16];
        res_nxt.packets       = ent_wdata.pk;
        res_nxt.total_bytes   = ent_wdata.by;
        res_nxt.first_time    = ent_wdata.ft;
        res_nxt.last_time     = ent_wdata.lt;
        ovld_nxt  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovld_nxt) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### hw/rtl/flow_table_update_unit.sv
`timescale 1ns / 1ps
// Flow table update unit: BUCKETS x WAYS entries, each hashed packet updates,
// restarts or inserts a flow or reports a full bucket, a drain beat reads one
// entry and idles it. After reset a clearing pass over all BUCKETS*WAYS entries
// (4096 by default) runs before the first beat is taken. A packet is compared
// way by way until it hits; an insert or a full bucket walks every way, and
// only hits and inserts are written back. An out-of-range drain reads nothing.
// Input is taken again in the cycle after the result beat is accepted. One key
// comparator walks the ways over the single port of the entry memory.
module flow_table_update_unit #(
  parameter int unsigned BUCKETS = ftu_pkg::BucketsDef,
  parameter int unsigned WAYS    = ftu_pkg::WaysDef
) (
  input  logic      clk,
  input  logic      rst_n,
  ftu_in_if.sink    in_ch,
  ftu_out_if.source out_ch
);
  import ftu_pkg::*;
  localparam int unsigned Entries = BUCKETS * WAYS;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;

  logic [AddrW-1:0] addr;
  logic             ent_we, flg_we;
  entry_t           ent_wdata, ent_rdata;
  logic [1:0]       flg_wdata, flg_rdata;

  ftu_seq #(.Buckets(BUCKETS), .Ways(WAYS), .AddrW(AddrW)) u_seq (
    .clk, .rst_n, .in_ch, .out_ch, .addr, .ent_we, .ent_wdata,
    .flg_we, .flg_wdata, .ent_rdata, .flg_rdata
  );

  ftu_store #(.Entries(Entries), .AddrW(AddrW)) u_store (
    .clk, .addr, .ent_we, .ent_wdata, .flg_we, .flg_wdata, .ent_rdata, .flg_rdata
  );
endmodule

### hw/rtl/ftu_checker.sv
`timescale 1ns / 1ps
// port checker for the flow table update unit, bound to the top level
// depends on ftu_pkg and the channel interfaces
module ftu_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] out_status
);
  import ftu_pkg::*;
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= 3'd5)) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind flow_table_update_unit ftu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.data.status)
);

### dv/tb_flow_table_update_unit.sv
`timescale 1ns / 1ps
// testbench for flow_table_update_unit: directed and random packet and drain beats
// checked against a built-in model of the hashed flow table
// depends on ftu_pkg, ftu_if and the unit itself
module tb_flow_table_update_unit;
  import ftu_pkg::*;

  localparam int unsigned NumEntries = BucketsDef * WaysDef;
  localparam int unsigned HotBuckets = 8;
  localparam int unsigned FlowsPerBkt = 6;

  typedef struct {
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
  } flow_key_t;

  logic clk;
  logic rst_n;

  ftu_in_if  in_ch (clk);
  ftu_out_if out_ch (clk);

  flow_table_update_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  bit        tbl_alloc [NumEntries];
  bit        tbl_active[NumEntries];
  entry_t    tbl_entry [NumEntries];
  out_beat_t flow_results_q[$];
  flow_key_t hot_flows[HotBuckets * FlowsPerBkt];
  int        err_count;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(3_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [BktW-1:0] hash_bucket(logic [31:0] sip, logic [31:0] dip,
                                                  logic [15:0] sp, logic [15:0] dp);
    logic [31:0] h;
    h = sip ^ dip ^ {dp, sp};
    return BktW'(h % BucketsDef);
  endfunction

  // works out the result of one beat and updates the table copy
  function automatic out_beat_t table_outcome(in_beat_t b);
    out_beat_t   r;
    logic [31:0] ports;
    int unsigned bkt, e, free_way;
    bit          found;
    ports = {b.dst_port, b.src_port};
    r = '0;
    found = 1'b0;
    if (b.mode[0]) begin
      r.bucket = b.drain_bucket;
      r.way    = b.drain_way;
      r.status = ST_DRAIN_IDLE;
      e = b.drain_bucket * WaysDef + b.drain_way;
      if (b.drain_bucket < BucketsDef && b.drain_way < WaysDef && tbl_alloc[e]) begin
        r.status        = tbl_active[e] ? ST_DRAIN_ACTIVE : ST_DRAIN_IDLE;
        r.flow_src_ip   = tbl_entry[e].sip;
        r.flow_dst_ip   = tbl_entry[e].dip;
        r.flow_src_port = tbl_entry[e].ports[15:0];
        r.flow_dst_port = tbl_entry[e].ports[31:16];
        r.packets       = tbl_entry[e].pk;
        r.total_bytes   = tbl_entry[e].by;
        r.first_time    = tbl_entry[e].ft;
        r.last_time     = tbl_entry[e].lt;
        tbl_active[e] = 1'b0;
      end
      return r;
    end
    bkt = hash_bucket(b.src_ip, b.dst_ip, b.src_port, b.dst_port);
    r.bucket = BktW'(bkt);
    free_way = WaysDef;
    for (int unsigned w = 0; w < WaysDef; w++) begin
      e = bkt * WaysDef + w;
      if (tbl_alloc[e] && tbl_entry[e].sip == b.src_ip && tbl_entry[e].dip == b.dst_ip &&
          tbl_entry[e].ports == ports) begin
        if (tbl_active[e]) begin
          tbl_entry[e].pk = tbl_entry[e].pk + 1;
          tbl_entry[e].by = tbl_entry[e].by + 64'(b.pkt_len);
          tbl_entry[e].lt = b.stamp;
          r.status = ST_UPDATED;
        end else begin
          tbl_entry[e].pk = 1;
          tbl_entry[e].by = 64'(b.pkt_len);
          tbl_entry[e].ft = b.stamp;
          tbl_entry[e].lt = b.stamp;
          r.status = ST_RESTARTED;
        end
        tbl_active[e] = 1'b1;
        free_way = w;
        found = 1'b1;
        break;
      end
      if (free_way == WaysDef && (!tbl_alloc[e] || !tbl_active[e])) free_way = w;
    end
    if (free_way == WaysDef) begin
      r.status        = ST_FULL;
      r.flow_src_ip   = b.src_ip;
      r.flow_dst_ip   = b.dst_ip;
      r.flow_src_port = b.src_port;
      r.flow_dst_port = b.dst_port;
      return r;
    end
    e = bkt * WaysDef + free_way;
    if (!found) begin
      r.status = ST_INSERTED;
      tbl_alloc[e]  = 1'b1;
      tbl_active[e] = 1'b1;
      tbl_entry[e].sip   = b.src_ip;
      tbl_entry[e].dip   = b.dst_ip;
      tbl_entry[e].ports = ports;
      tbl_entry[e].pk    = 1;
      tbl_entry[e].by    = 64'(b.pkt_len);
      tbl_entry[e].ft    = b.stamp;
      tbl_entry[e].lt    = b.stamp;
    end
    r.way           = WayW'(free_way);
    r.flow_src_ip   = tbl_entry[e].sip;
    r.flow_dst_ip   = tbl_entry[e].dip;
    r.flow_src_port = tbl_entry[e].ports[15:0];
    r.flow_dst_port = tbl_entry[e].ports[31:16];
    r.packets       = tbl_entry[e].pk;
    r.total_bytes   = tbl_entry[e].by;
    r.first_time    = tbl_entry[e].ft;
    r.last_time     = tbl_entry[e].lt;
    return r;
  endfunction

  function automatic in_beat_t packet_beat(flow_key_t k, logic [15:0] len, logic [63:0] stamp);
    in_beat_t b;
    b = '0;
    b.src_ip   = k.sip;
    b.dst_ip   = k.dip;
    b.src_port = k.sp;
    b.dst_port = k.dp;
    b.pkt_len  = len;
    b.stamp    = stamp;
    b.drain_bucket = BktW'($urandom);
    b.drain_way    = WayW'($urandom);
    return b;
  endfunction

  function automatic in_beat_t drain_beat(int unsigned bkt, int unsigned w);
    in_beat_t b;
    b = '0;
    b.mode         = 1'b1;
    b.drain_bucket = BktW'(bkt);
    b.drain_way    = WayW'(w);
    b.src_ip       = $urandom;
    b.stamp        = {$urandom, $urandom};
    return b;
  endfunction

  function automatic flow_key_t flow_in_bucket(int unsigned bkt);
    flow_key_t   k;
    logic [BktW-1:0] h;
    k.sip = $urandom;
    k.dip = $urandom;
    k.sp  = 16'($urandom);
    k.dp  = 16'($urandom);
    h = hash_bucket(k.sip, k.dip, k.sp, k.dp);
    k.dip[BktW-1:0] = k.dip[BktW-1:0] ^ h ^ BktW'(bkt);
    return k;
  endfunction

  function automatic flow_key_t random_flow();
    flow_key_t k;
    k.sip = $urandom;
    k.dip = $urandom;
    k.sp  = 16'($urandom);
    k.dp  = 16'($urandom);
    return k;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_beat(in_beat_t b);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else begin
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    flow_results_q.push_back(table_outcome(b));
    burst_left--;
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (flow_results_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        err_count++;
      end else begin
        out_beat_t x;
        x = flow_results_q.pop_front();
        check_field("status", x.status, out_ch.data.status);
        check_field("bucket", x.bucket, out_ch.data.bucket);
        check_field("way", x.way, out_ch.data.way);
        check_field("flow_src_ip", x.flow_src_ip, out_ch.data.flow_src_ip);
        check_field("flow_dst_ip", x.flow_dst_ip, out_ch.data.flow_dst_ip);
        check_field("flow_src_port", x.flow_src_port, out_ch.data.flow_src_port);
        check_field("flow_dst_port", x.flow_dst_port, out_ch.data.flow_dst_port);
        check_field("packets", x.packets, out_ch.data.packets);
        check_field("total_bytes", x.total_bytes, out_ch.data.total_bytes);
        check_field("first_time", x.first_time, out_ch.data.first_time);
        check_field("last_time", x.last_time, out_ch.data.last_time);
      end
    end
  end

  // receiver stall pattern: all ones or a random 16-bit mask, reloaded on a phase counter
  logic [15:0] ready_pat;
  int unsigned ready_phase;
  initial begin
    ready_pat   = '1;
    ready_phase = 0;
  end
  always @(negedge clk) begin
    if (ready_phase % 64 == 0) begin
      ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
    end
    out_ch.ready <= ready_pat[ready_phase % 16];
    ready_phase  <= ready_phase + 1;
  end

  task automatic test_extremes();
    flow_key_t k0, k1;
    k0 = '{32'h0, 32'h0, 16'h0, 16'h0};
    k1 = '{32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff};
    send_beat(packet_beat(k0, 16'h0, 64'h0));
    send_beat(packet_beat(k0, 16'hffff, 64'hffff_ffff_ffff_ffff));
    send_beat(packet_beat(k1, 16'hffff, 64'hffff_ffff_ffff_ffff));
    send_beat(packet_beat(k1, 16'hffff, 64'h0));
    send_beat(drain_beat(BucketsDef - 1, 0));
    send_beat(drain_beat(BucketsDef - 1, 0));
    send_beat(packet_beat(k1, 16'h1234, 64'h8000_0000_0000_0001));
    send_beat(drain_beat(0, WaysDef - 1));
    send_beat(drain_beat(0, 0));
  endtask

  task automatic test_bucket_overflow();
    flow_key_t k[5];
    for (int i = 0; i < 5; i++) k[i] = flow_in_bucket(77);
    for (int i = 0; i < 5; i++) send_beat(packet_beat(k[i], 16'($urandom), rand64()));
    send_beat(drain_beat(77, 2));
    send_beat(packet_beat(k[4], 16'd100, rand64()));
    send_beat(packet_beat(k[2], 16'd200, rand64()));
    send_beat(packet_beat(k[4], 16'd300, rand64()));
    send_beat(drain_beat(77, 1));
    send_beat(drain_beat(77, 1));
    send_beat(packet_beat(k[1], 16'd400, rand64()));
    send_beat(packet_beat(k[1], 16'd500, rand64()));
  endtask

  task automatic test_random_traffic(int unsigned n_beats);
    int unsigned pick, sel;
    for (int i = 0; i < HotBuckets * FlowsPerBkt; i++) begin
      hot_flows[i] = flow_in_bucket((i / FlowsPerBkt) * 131 + 5);
    end
    for (int unsigned i = 0; i < n_beats; i++) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, HotBuckets * FlowsPerBkt - 1);
      if (pick < 65) begin
        send_beat(packet_beat(hot_flows[sel], 16'($urandom), rand64()));
      end else if (pick < 80) begin
        send_beat(packet_beat(random_flow(), 16'($urandom), rand64()));
      end else if (pick < 95) begin
        send_beat(drain_beat((sel / FlowsPerBkt) * 131 + 5, $urandom_range(0, WaysDef - 1)));
      end else begin
        send_beat(drain_beat($urandom_range(0, BucketsDef - 1), $urandom_range(0, WaysDef - 1)));
      end
    end
  endtask

  initial begin
    err_count    = 0;
    burst_left   = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_bucket_overflow();
    test_random_traffic(1030);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (flow_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
